// File: rtl/sipq_pkg.sv
// Package for the sorted-insert priority queue.
// Holds default sizes, the operation code and the control structs shared by
// the queue core and the top level. Depends on nothing.
package sipq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_KEY_BITS    = 24;
  localparam int DEF_TAG_BITS    = 16;

  // The running key total is a fixed 28-bit field that wraps.
  localparam int TOTAL_BITS = 28;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } sipq_op_t;

  // Command from the channel side to the queue core.
  typedef struct packed {
    logic     start;
    sipq_op_t op;
  } sipq_cmd_t;

  // Status from the queue core back to the channel side.
  typedef struct packed {
    logic idle;
    logic done;
  } sipq_stat_t;

endpackage

// File: rtl/sipq_if.sv
// Valid/ready channel interfaces of the sorted-insert priority queue.
// One interface for the input item, one for the result item.
// Depends on sipq_pkg.
interface sipq_in_if
  import sipq_pkg::*;
#(
  parameter int TAG_BITS = DEF_TAG_BITS,
  parameter int KEY_BITS = DEF_KEY_BITS
);
  logic                valid;
  logic                ready;
  logic                operation;
  logic [TAG_BITS-1:0] entry_tag;
  logic [KEY_BITS-1:0] entry_key;

  modport source (output valid, operation, entry_tag, entry_key, input ready);
  modport sink   (input valid, operation, entry_tag, entry_key, output ready);
endinterface

interface sipq_out_if
  import sipq_pkg::*;
#(
  parameter int TAG_BITS   = DEF_TAG_BITS,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int COUNT_BITS = $clog2(DEF_QUEUE_DEPTH + 1)
);
  logic                  valid;
  logic                  ready;
  logic [TAG_BITS-1:0]   head_tag;
  logic [KEY_BITS-1:0]   head_key;
  logic [COUNT_BITS-1:0] entry_count;
  logic [TOTAL_BITS-1:0] key_total;
  logic                  is_empty;
  logic                  rejected;

  modport source (output valid, head_tag, head_key, entry_count, key_total,
                  is_empty, rejected, input ready);
  modport sink   (input valid, head_tag, head_key, entry_count, key_total,
                  is_empty, rejected, output ready);
endinterface

// File: rtl/sipq_core.sv
// Queue core: entry memory, count, key total, cached head and the sequencer
// that walks the memory one entry per cycle with a single key comparator.
// Depends on sipq_pkg.
module sipq_core
  import sipq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int TAG_BITS    = DEF_TAG_BITS,
  parameter int COUNT_BITS  = $clog2(DEF_QUEUE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sipq_cmd_t             cmd,
  input  logic [TAG_BITS-1:0]   in_tag,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic                  hold,
  output sipq_stat_t            stat,
  output logic [TAG_BITS-1:0]   res_head_tag,
  output logic [KEY_BITS-1:0]   res_head_key,
  output logic [COUNT_BITS-1:0] res_count,
  output logic [TOTAL_BITS-1:0] res_total,
  output logic                  res_rejected
);

  localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int ENT_BITS = TAG_BITS + KEY_BITS;
  localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_PLACE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  sipq_op_t              op_r, op_nxt;
  logic [TAG_BITS-1:0]   tag_r, tag_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic                  rej_r, rej_nxt;
  logic [IDX_BITS-1:0]   idx_r, idx_nxt;
  logic [IDX_BITS-1:0]   place_r, place_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic [TAG_BITS-1:0]   head_tag_r, head_tag_nxt;
  logic [KEY_BITS-1:0]   head_key_r, head_key_nxt;

  logic [ENT_BITS-1:0]   mem [QUEUE_DEPTH];
  logic [ENT_BITS-1:0]   rd_data_r;
  logic                  rd_en, wr_en;
  logic [IDX_BITS-1:0]   rd_addr, wr_addr;
  logic [ENT_BITS-1:0]   wr_data;

  logic [KEY_BITS-1:0]   rd_key;
  logic [TAG_BITS-1:0]   rd_tag;
  logic                  key_ge, key_eq, shift_up;
  logic [COUNT_BITS-1:0] count_m1;
  logic [TOTAL_BITS+KEY_BITS-1:0] new_key_wide, head_key_wide;
  logic                  done;

  assign rd_key   = rd_data_r[KEY_BITS-1:0];
  assign rd_tag   = rd_data_r[ENT_BITS-1:KEY_BITS];
  assign count_m1 = count_r - COUNT_BITS'(1);

  assign new_key_wide  = {{TOTAL_BITS{1'b0}}, key_r};
  assign head_key_wide = {{TOTAL_BITS{1'b0}}, head_key_r};

  // A stored entry moves up when the new key belongs ahead of it. The head
  // moves only for a strictly lower key; all others move for an equal key too.
  assign key_ge   = rd_key >= key_r;
  assign key_eq   = rd_key == key_r;
  assign shift_up = (idx_r == '0) ? (key_ge && !key_eq) : key_ge;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    tag_nxt      = tag_r;
    key_nxt      = key_r;
    rej_nxt      = rej_r;
    idx_nxt      = idx_r;
    place_nxt    = place_r;
    count_nxt    = count_r;
    total_nxt    = total_r;
    head_tag_nxt = head_tag_r;
    head_key_nxt = head_key_r;
    rd_en        = 1'b0;
    rd_addr      = idx_r;
    wr_en        = 1'b0;
    wr_addr      = idx_r;
    wr_data      = rd_data_r;
    done         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          op_nxt  = cmd.op;
          tag_nxt = in_tag;
          key_nxt = in_key;
          rej_nxt = 1'b0;
          if (cmd.op == OP_INSERT) begin
            if (count_r == FULL_COUNT) begin
              rej_nxt   = 1'b1;
              state_nxt = S_DONE;
            end else if (count_r == '0) begin
              place_nxt = '0;
              state_nxt = S_PLACE;
            end else begin
              // Walk down from the tail entry.
              rd_en     = 1'b1;
              rd_addr   = count_m1[IDX_BITS-1:0];
              idx_nxt   = count_m1[IDX_BITS-1:0];
              state_nxt = S_WALK;
            end
          end else begin
            if (count_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              total_nxt = total_r - head_key_wide[TOTAL_BITS-1:0];
              if (count_r == COUNT_BITS'(1)) begin
                count_nxt    = '0;
                head_tag_nxt = '0;
                head_key_nxt = '0;
                state_nxt    = S_DONE;
              end else begin
                // Walk up from the second entry, moving each one down.
                rd_en     = 1'b1;
                rd_addr   = IDX_BITS'(1);
                idx_nxt   = IDX_BITS'(1);
                state_nxt = S_WALK;
              end
            end
          end
        end
      end

      S_WALK: begin
        if (op_r == OP_INSERT) begin
          if (shift_up) begin
            wr_en   = 1'b1;
            wr_addr = idx_r + IDX_BITS'(1);
            if (idx_r == '0) begin
              place_nxt = '0;
              state_nxt = S_PLACE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = idx_r - IDX_BITS'(1);
              idx_nxt = idx_r - IDX_BITS'(1);
            end
          end else begin
            place_nxt = idx_r + IDX_BITS'(1);
            state_nxt = S_PLACE;
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = idx_r - IDX_BITS'(1);
          if (idx_r == IDX_BITS'(1)) begin
            head_tag_nxt = rd_tag;
            head_key_nxt = rd_key;
          end
          if (COUNT_BITS'(idx_r) == count_m1) begin
            count_nxt = count_m1;
            state_nxt = S_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + IDX_BITS'(1);
            idx_nxt = idx_r + IDX_BITS'(1);
          end
        end
      end

      S_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = place_r;
        wr_data   = {tag_r, key_r};
        count_nxt = count_r + COUNT_BITS'(1);
        total_nxt = total_r + new_key_wide[TOTAL_BITS-1:0];
        if (place_r == '0) begin
          head_tag_nxt = tag_r;
          head_key_nxt = key_r;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!hold) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      total_r    <= '0;
      head_tag_r <= '0;
      head_key_r <= '0;
      rej_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      total_r    <= total_nxt;
      head_tag_r <= head_tag_nxt;
      head_key_r <= head_key_nxt;
      rej_r      <= rej_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    tag_r   <= tag_nxt;
    key_r   <= key_nxt;
    idx_r   <= idx_nxt;
    place_r <= place_nxt;
  end

  assign stat.idle    = (state_r == S_IDLE);
  assign stat.done    = done;
  assign res_head_tag = head_tag_r;
  assign res_head_key = head_key_r;
  assign res_count    = count_r;
  assign res_total    = total_r;
  assign res_rejected = rej_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count exceeds queue depth");

  a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_key_r == '0 && head_tag_r == '0))
    else $error("empty queue reports a nonzero head");

  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("walk reads and writes the same entry in one cycle");

  a_reject_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (done && rej_r) |-> (count_r == FULL_COUNT))
    else $error("insert rejected while the queue has room");

  a_done_not_held: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !hold)
    else $error("result handed over while the output slot is full");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !cmd.start) |=> $stable(count_r))
    else $error("entry count changed with no item in progress");

endmodule

// File: rtl/sorted_insert_priority_queue.sv
// Top level of the sorted-insert priority queue: channel handshakes, the
// result register and the queue core.
// Depends on sipq_pkg, sipq_if and sipq_core.
//
//   channel  dir  fields                                           handshake
//   in_ch    in   operation, entry_tag, entry_key                  valid/ready
//   out_ch   out  head_tag, head_key, entry_count, key_total,       valid/ready
//                 is_empty, rejected
//
// An insert walks down from the tail entry, moving up the stored entries that
// must make room, m of them (0 to QUEUE_DEPTH-1), and then places the new entry;
// a full-queue insert is refused without a walk. A remove drops the head and walks
// up from the second entry, moving each one down;
// the walk reads and writes one entry per cycle through the single memory port pair.
// One item is in work at a time; in_ch.ready is high while the core is idle,
// also while a finished result waits in the output register.
// Reset is synchronous and empties the queue at once; the memory needs no clearing.
// A stalled output holds the next result in the core until the register frees.
module sorted_insert_priority_queue
  import sipq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int TAG_BITS    = DEF_TAG_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  sipq_in_if.sink           in_ch,
  sipq_out_if.source        out_ch
);

  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  sipq_cmd_t             cmd;
  sipq_stat_t            stat;
  logic                  hold;
  logic [TAG_BITS-1:0]   res_head_tag;
  logic [KEY_BITS-1:0]   res_head_key;
  logic [COUNT_BITS-1:0] res_count;
  logic [TOTAL_BITS-1:0] res_total;
  logic                  res_rejected;

  logic                  out_valid_r, out_valid_nxt;
  logic [TAG_BITS-1:0]   out_head_tag_r;
  logic [KEY_BITS-1:0]   out_head_key_r;
  logic [COUNT_BITS-1:0] out_count_r;
  logic [TOTAL_BITS-1:0] out_total_r;
  logic                  out_rejected_r;

  assign in_ch.ready = stat.idle;
  assign cmd.start   = in_ch.valid && stat.idle;
  assign cmd.op      = sipq_op_t'(in_ch.operation);
  assign hold        = out_valid_r && !out_ch.ready;

  sipq_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .TAG_BITS    (TAG_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_tag       (in_ch.entry_tag),
    .in_key       (in_ch.entry_key),
    .hold         (hold),
    .stat         (stat),
    .res_head_tag (res_head_tag),
    .res_head_key (res_head_key),
    .res_count    (res_count),
    .res_total    (res_total),
    .res_rejected (res_rejected)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stat.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_head_tag_r <= res_head_tag;
      out_head_key_r <= res_head_key;
      out_count_r    <= res_count;
      out_total_r    <= res_total;
      out_rejected_r <= res_rejected;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.head_tag    = out_head_tag_r;
  assign out_ch.head_key    = out_head_key_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.key_total   = out_total_r;
  assign out_ch.is_empty    = (out_count_r == '0);
  assign out_ch.rejected    = out_rejected_r;

endmodule

// File: tb/sv/sorted_insert_priority_queue_tb.sv
// Self-checking testbench for sorted_insert_priority_queue: directed and random
// insert/remove items with a scoreboard that mirrors the sorted queue.
// Depends on sipq_pkg, the sipq_in_if/sipq_out_if interfaces and the RTL top level.
module sorted_insert_priority_queue_tb
  import sipq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QD          = DEF_QUEUE_DEPTH;
  localparam int KEY_W       = DEF_KEY_BITS;
  localparam int TAG_W       = DEF_TAG_BITS;
  localparam int CNT_W       = $clog2(DEF_QUEUE_DEPTH + 1);
  localparam int RANDOM_ITEMS = 2000;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [TAG_W-1:0]      head_tag;
    logic [KEY_W-1:0]      head_key;
    logic [CNT_W-1:0]      entry_count;
    logic [TOTAL_BITS-1:0] key_total;
    logic                  is_empty;
    logic                  rejected;
  } queue_status_t;

  class head_status_checker;
    logic [KEY_W-1:0]      keys [QD];
    logic [TAG_W-1:0]      tags [QD];
    int                    used;
    logic [TOTAL_BITS-1:0] total;
    queue_status_t         expected_status[$];
    int                    failures;

    function new();
      used = 0;
      total = '0;
      failures = 0;
    endfunction

    function int depth_used();
      return used;
    endfunction

    function logic [KEY_W-1:0] stored_key(int idx);
      return keys[idx];
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // Applies one operation to the mirrored queue and returns the status it leaves.
    function queue_status_t next_head_status(sipq_op_t op, logic [TAG_W-1:0] tag,
                                             logic [KEY_W-1:0] key);
      queue_status_t s;
      int            slot;
      bit            refused;
      refused = 1'b0;
      if (op == OP_INSERT) begin
        if (used >= QD) begin
          refused = 1'b1;
        end else begin
          // A key equal to the head lands just after it; otherwise it goes
          // ahead of every stored entry with the same key.
          slot = 0;
          if (used != 0 && key >= keys[0]) begin
            slot = 1;
            while (slot < used && keys[slot] < key) slot++;
          end
          for (int i = used; i > slot; i--) begin
            keys[i] = keys[i-1];
            tags[i] = tags[i-1];
          end
          keys[slot] = key;
          tags[slot] = tag;
          used++;
          total = total + key;
        end
      end else if (used != 0) begin
        total = total - keys[0];
        for (int i = 1; i < used; i++) begin
          keys[i-1] = keys[i];
          tags[i-1] = tags[i];
        end
        used--;
      end
      s.head_tag    = (used != 0) ? tags[0] : '0;
      s.head_key    = (used != 0) ? keys[0] : '0;
      s.entry_count = CNT_W'(used);
      s.key_total   = total;
      s.is_empty    = (used == 0);
      s.rejected    = refused;
      return s;
    endfunction

    function void note_request(sipq_op_t op, logic [TAG_W-1:0] tag, logic [KEY_W-1:0] key);
      expected_status.push_back(next_head_status(op, tag, key));
    endfunction

    function void check_status(queue_status_t got);
      queue_status_t want;
      if (expected_status.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: tag %h key %h count %0d total %h empty %b rej %b",
                   got.head_tag, got.head_key, got.entry_count, got.key_total,
                   got.is_empty, got.rejected);
        return;
      end
      want = expected_status.pop_front();
      if (got.head_tag !== want.head_tag || got.head_key !== want.head_key ||
          got.entry_count !== want.entry_count || got.key_total !== want.key_total ||
          got.is_empty !== want.is_empty || got.rejected !== want.rejected) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mismatch: expected tag %h key %h count %0d total %h empty %b rej %b",
                   want.head_tag, want.head_key, want.entry_count, want.key_total,
                   want.is_empty, want.rejected);
          $display("          got      tag %h key %h count %0d total %h empty %b rej %b",
                   got.head_tag, got.head_key, got.entry_count, got.key_total,
                   got.is_empty, got.rejected);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   items_sent;
  bit   pressure_done;
  int   stall_cycles;

  head_status_checker board = new();

  sipq_in_if  in_ch ();
  sipq_out_if out_ch ();

  sorted_insert_priority_queue uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic send_item(input sipq_op_t op, input logic [TAG_W-1:0] tag,
                           input logic [KEY_W-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.entry_tag <= tag;
    in_ch.entry_key <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_request(op, tag, key);
    items_sent++;
  endtask

  // Mixes full-range keys with a small pool and copies of stored keys, so that
  // equal keys at the head and further down come up often.
  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return KEY_W'($urandom_range(0, 7) * 1000);
    if (roll == 2) return '0;
    if (roll == 3) return '1;
    if (roll < 6 && board.depth_used() != 0)
      return board.stored_key((roll == 4) ? 0 : $urandom_range(0, board.depth_used() - 1));
    return KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
  endfunction

  // Result side: checks accepted results and drives ready, with one long hold-off.
  initial begin
    queue_status_t seen;
    int            hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        seen.head_tag    = out_ch.head_tag;
        seen.head_key    = out_ch.head_key;
        seen.entry_count = out_ch.entry_count;
        seen.key_total   = out_ch.key_total;
        seen.is_empty    = out_ch.is_empty;
        seen.rejected    = out_ch.rejected;
        board.check_status(seen);
      end
      if (!pressure_done && items_sent >= 300) begin
        hold_left = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int insert_pct;
    int pct_choice;
    send_idle_pct = 18;
    recv_idle_pct = 51;
    items_sent = 0;
    pressure_done = 1'b0;
    stall_cycles = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_INSERT;
    in_ch.entry_tag <= '0;
    in_ch.entry_key <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: remove from empty, extreme keys and tags, equal keys at the
    // head and behind it, a full queue that refuses an insert, then a partial drain.
    send_item(OP_REMOVE, '1, '1);
    send_item(OP_INSERT, '1, '1);
    send_item(OP_INSERT, '0, '0);
    send_item(OP_INSERT, 16'd1, '0);
    send_item(OP_INSERT, 16'd2, '0);
    send_item(OP_INSERT, 16'd3, '1);
    send_item(OP_INSERT, 16'hAAAA, 24'h555555);
    send_item(OP_INSERT, 16'h5555, 24'hAAAAAA);
    for (int i = 0; i < QD - 7; i++)
      send_item(OP_INSERT, TAG_W'(16 + i), KEY_W'(i * 24'h100000 + 24'h12345));
    send_item(OP_INSERT, 16'hBEEF, 24'd1);
    repeat (7) send_item(OP_REMOVE, '0, '0);

    insert_pct = 55;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 18;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Runs of fill-heavy, drain-heavy and balanced traffic reach both the full
      // and the empty queue.
      if (n % 48 == 0) begin
        pct_choice = $urandom_range(0, 2);
        insert_pct = (pct_choice == 0) ? 80 : (pct_choice == 1) ? 20 : 55;
      end
      if ($urandom_range(0, 99) < insert_pct)
        send_item(OP_INSERT, TAG_W'($urandom_range(0, (1 << TAG_W) - 1)), pick_key());
      else
        send_item(OP_REMOVE, TAG_W'($urandom_range(0, (1 << TAG_W) - 1)),
                  KEY_W'($urandom_range(0, (1 << KEY_W) - 1)));
    end
    in_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
